[rtl/hwwu_pkg.sv]
// shared types, constants and microcode for the hebbian window weight update block
package hwwu_pkg;

  localparam int WEIGHT_W = 16;
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int PC_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_MAX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 2'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX_RST  = 16'd16384;
  localparam logic [WEIGHT_W-1:0] WEIGHT_STEP_RST = 16'd1638;
  localparam logic [TIME_W-1:0]   WINDOW_RST      = 32'd500;

  localparam logic OPC_POST = 1'b0;
  localparam logic OPC_PRE  = 1'b1;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_DISPATCH = 3'd0;
  localparam pc_t PC_FIRST    = 3'd1;
  localparam pc_t PC_LOAD     = 3'd2;
  localparam pc_t PC_WALK     = 3'd3;
  localparam pc_t PC_EVAL     = 3'd4;
  localparam pc_t PC_PUSH     = 3'd5;
  localparam pc_t PC_RESULT   = 3'd6;

  typedef enum logic [2:0] {
    UOP_DISPATCH,
    UOP_FIRST,
    UOP_LOAD,
    UOP_WALK,
    UOP_EVAL,
    UOP_PUSH,
    UOP_RESULT
  } uop_t;

  typedef struct packed {
    uop_t op;
    pc_t  jmp;
  } ctrl_t;

  typedef struct packed {
    logic branch;
    logic go;
  } seq_stat_t;

  function automatic ctrl_t ucode_rom(input pc_t pc);
    ctrl_t cw;
    case (pc)
      PC_DISPATCH: cw = '{op: UOP_DISPATCH, jmp: PC_PUSH};
      PC_FIRST:    cw = '{op: UOP_FIRST,    jmp: PC_DISPATCH};
      PC_LOAD:     cw = '{op: UOP_LOAD,     jmp: PC_DISPATCH};
      PC_WALK:     cw = '{op: UOP_WALK,     jmp: PC_EVAL};
      PC_EVAL:     cw = '{op: UOP_EVAL,     jmp: PC_RESULT};
      PC_PUSH:     cw = '{op: UOP_PUSH,     jmp: PC_DISPATCH};
      PC_RESULT:   cw = '{op: UOP_RESULT,   jmp: PC_DISPATCH};
      default:     cw = '{op: UOP_DISPATCH, jmp: PC_DISPATCH};
    endcase
    return cw;
  endfunction

  function automatic logic [TIME_W-1:0] abs_diff(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[rtl/hwwu_in_if.sv]
// input channel: opcode and event time with valid/ready
interface hwwu_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] event_time;

  modport source(output valid, output opcode, output event_time, input ready);
  modport sink(input valid, input opcode, input event_time, output ready);
endinterface

[rtl/hwwu_out_if.sv]
// result channel: weight and potentiation flag with valid/ready
interface hwwu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] weight_now;
  logic        potentiated;

  modport source(output valid, output weight_now, output potentiated, input ready);
  modport sink(input valid, input weight_now, input potentiated, output ready);
endinterface

[rtl/hwwu_ram.sv]
// generic single write port, single read port ram with registered read
module hwwu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/hwwu_seq.sv]
// microcode sequencer: step counter, control rom and branch logic
module hwwu_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  hwwu_pkg::seq_stat_t stat,
  output hwwu_pkg::ctrl_t   ctrl
);
  import hwwu_pkg::*;

  pc_t pc_r;
  pc_t pc_nxt;

  assign ctrl = ucode_rom(pc_r);

  always_comb begin
    if (stat.branch) begin
      pc_nxt = ctrl.jmp;
    end else if (stat.go) begin
      pc_nxt = pc_r + pc_t'(1);
    end else begin
      pc_nxt = pc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_DISPATCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[rtl/hebbian_window_weight_update_core.sv]
// top level: hebbian coincidence-window weight update for one synapse
//
// in_ch carries one word per item: opcode 0 stores a postsynaptic spike time
// in the ring, opcode 1 checks a presynaptic release time against the ring
// and may raise the weight by weight_step, bounded by weight_max.
// out_ch returns one word per item: the weight after it and a potentiated flag.
// cfg_we/cfg_index/cfg_wdata write weight_max (0), weight_step (1) and
// coincidence_window (2); write only while no item is in flight.
// a microcode sequencer runs each item; the ring sits in a ram with one read
// port, so the walk reads one entry per cycle.
// a post spike item runs dispatch, push and result; a check item runs
// dispatch, first, load, walk (ends early when the distance grows),
// eval and result; a skipped check (weight already full) goes via push.
// a new item is accepted when the sequencer is back at dispatch, even while
// the previous result still waits in the output register; if the receiver
// stalls, the next item finishes and holds at the result step.
// reset clears the weight, the ring (through per-entry valid bits), the
// newest slot pointer and loads the default register values.
module hebbian_window_weight_update_core #(
  parameter int RING_DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  hwwu_in_if.sink                        in_ch,
  hwwu_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [hwwu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hwwu_pkg::CFG_W-1:0]     cfg_wdata
);
  import hwwu_pkg::*;

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

  ctrl_t     ctrl;
  seq_stat_t stat;

  logic [WEIGHT_W-1:0] wmax_r;
  logic [WEIGHT_W-1:0] wstep_r;
  logic [TIME_W-1:0]   win_r;

  logic [WEIGHT_W-1:0] wgt_r;
  logic                pot_r;
  logic                op_r;
  logic [TIME_W-1:0]   time_r;
  logic [TIME_W-1:0]   best_r;
  logic [SLOT_W-1:0]   cnt_r;
  logic [SLOT_W-1:0]   rd_slot_r;
  logic [SLOT_W-1:0]   newest_r;
  logic [RING_DEPTH-1:0] ring_vld_r;
  logic                vld_q_r;

  logic                out_valid_r;
  logic [WEIGHT_W-1:0] out_wgt_r;
  logic                out_pot_r;

  logic                in_acc;
  logic [WEIGHT_W:0]   wsum;
  logic                eligible;
  logic [SLOT_W-1:0]   slot_back;
  logic [SLOT_W-1:0]   slot_fwd;
  logic [SLOT_W-1:0]   rd_addr;
  logic                ram_we;
  logic [TIME_W-1:0]   ram_rdata;
  logic [TIME_W-1:0]   rd_time;
  logic [TIME_W-1:0]   gap;
  logic                farther;
  logic                out_load;

  hwwu_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctrl (ctrl)
  );

  hwwu_ram #(
    .WIDTH(TIME_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_fwd),
    .wdata(time_r),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  assign in_ch.ready = (ctrl.op == UOP_DISPATCH);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign wsum     = {1'b0, wgt_r} + {1'b0, wstep_r};
  assign eligible = (wsum <= {1'b0, wmax_r});

  assign slot_back = (rd_slot_r == '0) ? SLOT_LAST : rd_slot_r - SLOT_W'(1);
  assign slot_fwd  = (newest_r == SLOT_LAST) ? '0 : newest_r + SLOT_W'(1);
  assign rd_addr   = (ctrl.op == UOP_FIRST) ? newest_r : slot_back;

  assign ram_we  = (ctrl.op == UOP_PUSH) && (op_r == OPC_POST);
  assign rd_time = vld_q_r ? ram_rdata : '0;
  assign gap     = abs_diff(time_r, rd_time);
  assign farther = (gap > best_r);

  assign out_load = !out_valid_r || out_ch.ready;

  always_comb begin
    stat = '{branch: 1'b0, go: 1'b0};
    case (ctrl.op)
      UOP_DISPATCH: begin
        stat.go     = in_acc;
        stat.branch = in_acc && !((in_ch.opcode == OPC_PRE) && eligible);
      end
      UOP_FIRST: stat.go = 1'b1;
      UOP_LOAD:  stat.go = 1'b1;
      UOP_WALK:  stat.branch = farther || (cnt_r == SLOT_LAST);
      UOP_EVAL:  stat.branch = 1'b1;
      UOP_PUSH:  stat.go = 1'b1;
      UOP_RESULT: stat.branch = out_load;
      default: stat = '{branch: 1'b0, go: 1'b0};
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wmax_r  <= WEIGHT_MAX_RST;
      wstep_r <= WEIGHT_STEP_RST;
      win_r   <= WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WEIGHT_MAX:  wmax_r  <= cfg_wdata[WEIGHT_W-1:0];
        REG_WEIGHT_STEP: wstep_r <= cfg_wdata[WEIGHT_W-1:0];
        REG_WINDOW:      win_r   <= cfg_wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    vld_q_r <= ring_vld_r[rd_addr];
    case (ctrl.op)
      UOP_DISPATCH: begin
        if (in_acc) begin
          op_r   <= in_ch.opcode;
          time_r <= in_ch.event_time;
        end
      end
      UOP_FIRST: rd_slot_r <= newest_r;
      UOP_LOAD: begin
        best_r    <= gap;
        rd_slot_r <= slot_back;
        cnt_r     <= SLOT_W'(1);
      end
      UOP_WALK: begin
        if (!farther) begin
          best_r    <= gap;
          rd_slot_r <= slot_back;
          cnt_r     <= cnt_r + SLOT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // synapse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wgt_r      <= '0;
      pot_r      <= 1'b0;
      newest_r   <= '0;
      ring_vld_r <= '0;
    end else begin
      case (ctrl.op)
        UOP_DISPATCH: begin
          if (in_acc) begin
            pot_r <= 1'b0;
          end
        end
        UOP_EVAL: begin
          if (best_r < win_r) begin
            wgt_r <= wsum[WEIGHT_W-1:0];
            pot_r <= (wstep_r != '0);
          end
        end
        UOP_PUSH: begin
          if (ram_we) begin
            newest_r             <= slot_fwd;
            ring_vld_r[slot_fwd] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((ctrl.op == UOP_RESULT) && out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.op == UOP_RESULT) && out_load) begin
      out_wgt_r <= wgt_r;
      out_pot_r <= pot_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.weight_now  = out_wgt_r;
  assign out_ch.potentiated = out_pot_r;

  a_ring_write_post_only: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (op_r == OPC_POST))
    else $error("ring written by a check word");

  a_walk_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == UOP_WALK) |-> (cnt_r <= SLOT_LAST) && (cnt_r != '0))
    else $error("walk count out of range");

  a_weight_changes_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(wgt_r) |-> $past(ctrl.op == UOP_EVAL))
    else $error("weight changed outside evaluation");

  a_pot_within_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pot_r) |-> (out_wgt_r <= wmax_r) && (out_wgt_r != '0))
    else $error("potentiated weight above bound");

endmodule

[verif/testbench.sv]
// self-checking testbench for the hebbian window weight update core
`timescale 1ns / 1ps

module testbench;
  import hwwu_pkg::*;

  localparam int DEPTH = 8;
  localparam int SETTLE_CYCLES = 4 + DEPTH + 4;
  localparam int NPHASE = 12;
  localparam int PHASE_WORDS = 106;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                pot;
  } weight_word_t;

  typedef struct {
    logic              op;
    logic [TIME_W-1:0] t;
    bit                known;
    logic [WEIGHT_W-1:0] w;
    logic              p;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  hwwu_in_if  in_ch();
  hwwu_out_if out_ch();

  hebbian_window_weight_update_core #(
    .RING_DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // synapse model state
  logic [WEIGHT_W-1:0] max_r;
  logic [WEIGHT_W-1:0] step_r;
  logic [TIME_W-1:0]   win_r;
  logic [WEIGHT_W-1:0] syn_w;
  logic [TIME_W-1:0]   spike_ring [DEPTH];
  int                  newest;

  weight_word_t expected_words[$];
  int errors = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [TIME_W-1:0] spike_gap(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic weight_word_t apply_event(input logic op, input logic [TIME_W-1:0] t);
    weight_word_t res;
    logic [WEIGHT_W-1:0] old_w;
    logic [WEIGHT_W:0] sum;
    logic [TIME_W-1:0] best;
    logic [TIME_W-1:0] d;
    int slot;
    bit stop;
    old_w = syn_w;
    if (op == OPC_POST) begin
      newest = (newest + 1) % DEPTH;
      spike_ring[newest] = t;
    end else begin
      sum = {1'b0, syn_w} + {1'b0, step_r};
      if (sum <= {1'b0, max_r}) begin
        slot = newest;
        best = spike_gap(t, spike_ring[slot]);
        stop = 1'b0;
        // walk back while the distance does not grow
        for (int k = 1; k < DEPTH; k++) begin
          if (!stop) begin
            slot = (slot == 0) ? DEPTH - 1 : slot - 1;
            d = spike_gap(t, spike_ring[slot]);
            if (d > best) stop = 1'b1;
            else best = d;
          end
        end
        if (best < win_r) syn_w = (sum > {1'b0, max_r}) ? max_r : sum[WEIGHT_W-1:0];
      end
    end
    res.weight = syn_w;
    res.pot = (syn_w > old_w);
    return res;
  endfunction

  task automatic report_error(input string msg);
    $display("error at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic send_word(input logic op, input logic [TIME_W-1:0] t, input bit known,
                           input weight_word_t typed);
    weight_word_t pred;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.event_time <= t;
    do @(posedge clk); while (!in_ch.ready);
    pred = apply_event(op, t);
    expected_words.push_back(known ? typed : pred);
  endtask

  task automatic write_regs(input logic [WEIGHT_W-1:0] wmax, input logic [WEIGHT_W-1:0] wstep,
                            input logic [TIME_W-1:0] win);
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_WEIGHT_MAX;
    cfg_wdata <= CFG_W'(wmax);
    @(posedge clk);
    cfg_index <= REG_WEIGHT_STEP;
    cfg_wdata <= CFG_W'(wstep);
    @(posedge clk);
    cfg_index <= REG_WINDOW;
    cfg_wdata <= CFG_W'(win);
    @(posedge clk);
    cfg_we <= 1'b0;
    max_r = wmax;
    step_r = wstep;
    win_r = win;
  endtask

  // result side: checks each word and stalls in bursts
  initial begin : result_side
    int stall_left;
    weight_word_t exp_w;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_error($sformatf("unexpected word, weight %0h", out_ch.weight_now));
        end else begin
          exp_w = expected_words.pop_front();
          if (out_ch.weight_now !== exp_w.weight)
            report_error($sformatf("weight_now %0h, expected %0h", out_ch.weight_now,
                                   exp_w.weight));
          if (out_ch.potentiated !== exp_w.pot)
            report_error($sformatf("potentiated %0b, expected %0b", out_ch.potentiated,
                                   exp_w.pot));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17);
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  initial begin : stimulus
    stim_row_t plan [25];
    weight_word_t typed;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] t;
    logic op;
    logic [WEIGHT_W-1:0] wmax;
    logic [WEIGHT_W-1:0] wstep;
    logic [TIME_W-1:0] win;
    int r;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OPC_POST;
    in_ch.event_time <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_WEIGHT_MAX;
    cfg_wdata <= '0;
    max_r = WEIGHT_MAX_RST;
    step_r = WEIGHT_STEP_RST;
    win_r = WINDOW_RST;
    syn_w = '0;
    newest = 0;
    for (int k = 0; k < DEPTH; k++) spike_ring[k] = '0;

    plan = '{
      // cleared ring counts as time 0
      '{OPC_PRE,  32'h0000_0000, 1'b1, 16'd1638, 1'b1},
      '{OPC_PRE,  32'hFFFF_FFFF, 1'b1, 16'd1638, 1'b0},
      '{OPC_POST, 32'd1000,      1'b1, 16'd1638, 1'b0},
      '{OPC_POST, 32'hFFFF_FFFF, 1'b1, 16'd1638, 1'b0},
      // one tick inside and right on the window edge
      '{OPC_PRE,  32'hFFFF_FE0C, 1'b0, 16'd0, 1'b0},
      '{OPC_PRE,  32'hFFFF_FE0B, 1'b0, 16'd0, 1'b0},
      '{OPC_PRE,  32'd1000,      1'b0, 16'd0, 1'b0},
      // walk stops before reaching the close entry
      '{OPC_POST, 32'd5000,      1'b0, 16'd0, 1'b0},
      '{OPC_POST, 32'd100000,    1'b0, 16'd0, 1'b0},
      '{OPC_POST, 32'd6000,      1'b0, 16'd0, 1'b0},
      '{OPC_PRE,  32'd5000,      1'b0, 16'd0, 1'b0},
      '{OPC_POST, 32'd7000,      1'b0, 16'd0, 1'b0},
      '{OPC_POST, 32'd8200,      1'b0, 16'd0, 1'b0},
      '{OPC_POST, 32'd7800,      1'b0, 16'd0, 1'b0},
      '{OPC_PRE,  32'd8000,      1'b0, 16'd0, 1'b0},
      '{OPC_PRE,  32'd7800,      1'b0, 16'd0, 1'b0},
      '{OPC_PRE,  32'd7800,      1'b0, 16'd0, 1'b0},
      // ring wraps, equal distances keep walking
      '{OPC_POST, 32'd10,        1'b0, 16'd0, 1'b0},
      '{OPC_POST, 32'd20,        1'b0, 16'd0, 1'b0},
      '{OPC_POST, 32'd30,        1'b0, 16'd0, 1'b0},
      '{OPC_POST, 32'd40,        1'b0, 16'd0, 1'b0},
      '{OPC_POST, 32'd50,        1'b0, 16'd0, 1'b0},
      '{OPC_POST, 32'd60,        1'b0, 16'd0, 1'b0},
      '{OPC_POST, 32'd70,        1'b0, 16'd0, 1'b0},
      '{OPC_PRE,  32'd35,        1'b0, 16'd0, 1'b0}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      typed.weight = plan[i].w;
      typed.pot = plan[i].p;
      send_word(plan[i].op, plan[i].t, plan[i].known, typed);
    end

    typed = '0;
    for (int p = 1; p <= NPHASE; p++) begin
      case (p)
        1: begin wmax = 16'hFFFF; wstep = 16'd37; win = 32'd2000; end
        2: begin wmax = 16'hFFFF; wstep = 16'd0; win = 32'hFFFF_FFFF; end
        3: begin wmax = 16'hFFFF; wstep = 16'($urandom_range(1, 200)); win = 32'd0; end
        4: begin wmax = 16'hFFFF; wstep = 16'hFFFF; win = 32'hFFFF_FFFF; end
        5: begin wmax = 16'd0; wstep = 16'd0; win = 32'hFFFF_FFFF; end
        6: begin
          // bound just above the weight so it saturates
          wmax = (syn_w > 16'd65435) ? 16'hFFFF : syn_w + 16'd100;
          wstep = 16'd40;
          win = 32'hFFFF_FFFF;
        end
        7: begin wmax = 16'd1000; wstep = 16'hFFFF; win = 32'hFFFF_FFFF; end
        NPHASE: begin wmax = 16'hFFFF; wstep = 16'd1; win = 32'hFFFF_FFFF; end
        default: begin
          wmax = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'hFFFF;
          wstep = 16'($urandom_range(0, 300));
          win = $urandom_range(0, 3000);
        end
      endcase
      write_regs(wmax, wstep, win);
      idle_on = (p % 4 != 3) && (p != NPHASE);
      base = '0;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 16 == 0) begin
          r = $urandom_range(0, 7);
          base = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_F000 : $urandom();
        end
        if (p == 1 && i == 40) hold_req = 1'b1;
        op = 1'($urandom_range(0, 1));
        // mostly clustered spike trains, some scattered noise
        if ($urandom_range(0, 9) < 7) t = base + $urandom_range(0, 4000);
        else t = $urandom();
        send_word(op, t, 1'b0, typed);
      end
    end

    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES + 8) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
rtl/hwwu_pkg.sv
rtl/hwwu_in_if.sv
rtl/hwwu_out_if.sv
rtl/hwwu_ram.sv
rtl/hwwu_seq.sv
rtl/hebbian_window_weight_update_core.sv
verif/testbench.sv
